>>> hdl/base64_stream_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// Each macro expands to one labeled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define B64SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("decoder assertion failed");

// Next-cycle implication.
`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("decoder assertion failed");

`endif

>>> hdl/b64sd_pkg.sv
package b64sd_pkg;

	// Input beat: one raw character and the end-of-message mark.
	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_message;
	} chr_beat_t;

	// Output beat: one result for every character.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       message_done;
	} dec_beat_t;

	// Character lookup result between the map and the residue logic.
	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sextet_t;

	// Residue fill, counted in pairs of bits (0, 2, 4 or 6 bits held).
	typedef enum logic [1:0] {
		FILL_0 = 2'd0,
		FILL_2 = 2'd1,
		FILL_4 = 2'd2,
		FILL_6 = 2'd3
	} fill_t;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_UNDER   = 8'h5F;

	localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SEXTET_62         = 6'd62;
	localparam logic [5:0] SEXTET_63         = 6'd63;

endpackage

>>> hdl/base64_stream_decoder.sv
// Lenient base64 stream decoder, one character per beat.
// Input channel chr_*: chr_data carries one raw character and an
// end-of-message mark. Output channel dec_*: exactly one result beat per
// input beat, carrying byte_valid, the decoded byte (zero when none) and
// message_done, a copy of the end-of-message mark.
// Both alphabets are decoded ('+'/'-' = 62, '/'/'_' = 63); every other
// character, padding included, leaves the residue alone but for an end mark.
// A beat passes an input register, then a result register, to reach dec_*.
// Throughput: one beat per cycle unless the receiver stalls; the residue
// update is a single lookup, shift and select between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; chr_ready falls once both are full.
// Reset clears both valid flags and empties the residue; leftover bits at
// the end of a message are discarded without a partial byte.
module base64_stream_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  chr_valid,
	output logic                  chr_ready,
	input  b64sd_pkg::chr_beat_t  chr_data,
	output logic                  dec_valid,
	input  logic                  dec_ready,
	output b64sd_pkg::dec_beat_t  dec_data
);
	import b64sd_pkg::*;

	`include "base64_stream_decoder_assert.svh"

	logic      valid_s1;
	chr_beat_t beat_s1;
	logic      valid_s2;
	dec_beat_t beat_s2;
	logic      load_s2;
	logic      advance;
	sextet_t   sextet;
	fill_t     fill_q;
	fill_t     fill_next;
	logic [5:0] residue_q;
	logic [5:0] residue_next;
	dec_beat_t result;

	// Pipeline flow control.
	assign load_s2   = !valid_s2 || dec_ready;
	assign advance   = valid_s1 && load_s2;
	assign chr_ready = !valid_s1 || load_s2;
	assign dec_valid = valid_s2;
	assign dec_data  = beat_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr_ready) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_ready && chr_valid) begin
			beat_s1 <= chr_data;
		end
	end

	b64sd_sextet u_sextet (
		.char_in (beat_s1.char_in),
		.sextet  (sextet)
	);

	// Residue update: a new sextet joins below the held bits. The new
	// residue after a hit is the low bits of the sextet, unless an end mark
	// clears it; bits above the fill level are never read.
	always_comb begin
		result.byte_valid   = 1'b0;
		result.data_byte    = '0;
		result.message_done = beat_s1.end_of_message;
		fill_next           = fill_q;
		residue_next        = residue_q;
		if (sextet.hit) begin
			residue_next = sextet.value;
			unique case (fill_q)
				FILL_0: begin
					fill_next = FILL_6;
				end
				FILL_2: begin
					fill_next         = FILL_0;
					result.byte_valid = 1'b1;
					result.data_byte  = {residue_q[1:0], sextet.value};
				end
				FILL_4: begin
					fill_next         = FILL_2;
					result.byte_valid = 1'b1;
					result.data_byte  = {residue_q[3:0], sextet.value[5:2]};
				end
				FILL_6: begin
					fill_next         = FILL_4;
					result.byte_valid = 1'b1;
					result.data_byte  = {residue_q, sextet.value[5:4]};
				end
				default: begin
					fill_next = FILL_0;
				end
			endcase
		end
		if (beat_s1.end_of_message) begin
			fill_next    = FILL_0;
			residue_next = '0;
		end
	end

	// Residue state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= FILL_0;
			residue_q <= '0;
		end else if (advance) begin
			fill_q    <= fill_next;
			residue_q <= residue_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s2 <= result;
		end
	end

	// The residue moves only when a beat passes into the result register.
	`B64SD_ASSERT_NEXT(a_fill_hold, clk, arst_n, !advance, $stable(fill_q) && $stable(residue_q))
	// An end-of-message beat always leaves the residue empty.
	`B64SD_ASSERT_NEXT(a_eom_clears, clk, arst_n, advance && beat_s1.end_of_message, fill_q == FILL_0)
	// A sextet arriving on a nonempty residue completes a byte.
	`B64SD_ASSERT_NEXT(a_byte_out, clk, arst_n, advance && sextet.hit && fill_q != FILL_0, dec_valid && dec_data.byte_valid)
	// A result without a byte carries a zero data field.
	`B64SD_ASSERT_NOW(a_zero_data, clk, arst_n, dec_valid && !dec_data.byte_valid, dec_data.data_byte == 8'd0)

endmodule

>>> hdl/b64sd_sextet.sv
module b64sd_sextet (
	input  logic [7:0]        char_in,
	output b64sd_pkg::sextet_t sextet
);
	import b64sd_pkg::*;

	logic [7:0] off_upper;
	logic [7:0] off_lower;
	logic [7:0] off_digit;

	// Offsets from the start of each alphabet range.
	assign off_upper = char_in - CHAR_UPPER_A;
	assign off_lower = char_in - CHAR_LOWER_A;
	assign off_digit = char_in - CHAR_DIGIT_0;

	// Map both alphabets; anything else is reported as a miss.
	always_comb begin
		sextet.hit   = 1'b1;
		sextet.value = '0;
		if (char_in >= CHAR_UPPER_A && char_in <= CHAR_UPPER_Z) begin
			sextet.value = off_upper[5:0];
		end else if (char_in >= CHAR_LOWER_A && char_in <= CHAR_LOWER_Z) begin
			sextet.value = off_lower[5:0] + SEXTET_LOWER_BASE;
		end else if (char_in >= CHAR_DIGIT_0 && char_in <= CHAR_DIGIT_9) begin
			sextet.value = off_digit[5:0] + SEXTET_DIGIT_BASE;
		end else if (char_in == CHAR_PLUS || char_in == CHAR_MINUS) begin
			sextet.value = SEXTET_62;
		end else if (char_in == CHAR_SLASH || char_in == CHAR_UNDER) begin
			sextet.value = SEXTET_63;
		end else begin
			sextet.hit = 1'b0;
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import b64sd_pkg::*;

	// One directed row: the character beat, whether the result is typed in,
	// and the typed result itself (zero where the decoder model decides).
	typedef struct packed {
		chr_beat_t beat;
		logic      typed;
		dec_beat_t result;
	} stim_row_t;

	localparam int ROW_COUNT = 25;
	localparam int PHASE_ITEMS = 250;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TX_IDLE_PCT [4] = '{0, 88, 0, 9};
	localparam int RX_STALL_PCT [4] = '{0, 0, 88, 9};

	// Columns: character, end mark, typed, byte_valid, data_byte, message_done.
	localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
		{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"=",   1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"T",   1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"W",   1'b0, 1'b1, 1'b1, 8'h4D, 1'b0},
		{8'h0A, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"F",   1'b0, 1'b1, 1'b1, 8'h61, 1'b0},
		{"u",   1'b0, 1'b1, 1'b1, 8'h6E, 1'b0},
		{"A",   1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"/",   1'b1, 1'b1, 1'b1, 8'h03, 1'b1},
		{"A",   1'b1, 1'b1, 1'b0, 8'h00, 1'b1},
		{" ",   1'b1, 1'b1, 1'b0, 8'h00, 1'b1},
		{"/",   1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
		{"/",   1'b0, 1'b1, 1'b1, 8'hFF, 1'b0},
		{"_",   1'b0, 1'b1, 1'b1, 8'hFF, 1'b0},
		{"-",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{"+",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{"z",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{"0",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{"9",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		{"Z",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{"a",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{8'h0D, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
		{8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		{"@",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      chr_valid = 1'b0;
	logic      chr_ready;
	chr_beat_t chr_data = '0;
	logic      dec_valid;
	logic      dec_ready = 1'b0;
	dec_beat_t dec_data;

	// Predictor state: bits not yet decoded and how many of them are held.
	logic [5:0] held_bits = '0;
	logic [2:0] held_count = '0;

	dec_beat_t owed_results [$];
	int        mismatch_count = 0;
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;

	base64_stream_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr_data  (chr_data),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_data  (dec_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Decode one character against the held residue and update it.
	function automatic dec_beat_t decode_char(input chr_beat_t beat);
		dec_beat_t   res;
		logic        hit;
		logic [5:0]  value;
		logic [11:0] joined;
		logic [3:0]  total;
		logic [3:0]  left;
		logic [7:0]  ch;
		res = '0;
		hit = 1'b1;
		value = '0;
		ch = beat.char_in;
		if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
			value = 6'(ch - CHAR_UPPER_A);
		end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
			value = 6'(ch - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
		end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
			value = 6'(ch - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
		end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
			value = SEXTET_62;
		end else if (ch == CHAR_SLASH || ch == CHAR_UNDER) begin
			value = SEXTET_63;
		end else begin
			hit = 1'b0;
		end

		// A sextet goes in below the held bits; a full byte leaves from the top.
		if (hit) begin
			joined = {held_bits, value};
			total = {1'b0, held_count} + 4'd6;
			if (total >= 4'd8) begin
				left = total - 4'd8;
				res.byte_valid = 1'b1;
				res.data_byte = 8'(joined >> left);
				held_bits = 6'(joined & ((12'd1 << left) - 12'd1));
				held_count = 3'(left);
			end else begin
				held_bits = joined[5:0];
				held_count = total[2:0];
			end
		end

		// The end mark drops whatever is left over.
		if (beat.end_of_message) begin
			held_bits = '0;
			held_count = '0;
		end
		res.message_done = beat.end_of_message;
		return res;
	endfunction

	// Offer one character beat, with random idle cycles ahead of it, and
	// record the result it owes once it is taken.
	task automatic send_beat(input chr_beat_t beat, input logic typed,
			input dec_beat_t typed_result);
		dec_beat_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_data <= beat;
		do @(posedge clk); while (!chr_ready);
		predicted = decode_char(beat);
		owed_results = {owed_results, (typed ? typed_result : predicted)};
	endtask

	// Result side: random stalls, and each taken beat is checked in order.
	always @(posedge clk) begin : result_check
		dec_beat_t want;
		if (arst_n && dec_valid && dec_ready) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result beat %h", dec_data);
				mismatch_count++;
			end else begin
				want = owed_results.pop_front();
				if (dec_data.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0h, got %0h",
						want.byte_valid, dec_data.byte_valid);
					mismatch_count++;
				end
				if (dec_data.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h",
						want.data_byte, dec_data.data_byte);
					mismatch_count++;
				end
				if (dec_data.message_done !== want.message_done) begin
					$error("message_done: expected %0h, got %0h",
						want.message_done, dec_data.message_done);
					mismatch_count++;
				end
			end
		end
		dec_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((chr_valid && chr_ready) || (dec_valid && dec_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL base64_stream_decoder");
		$finish;
	end

	initial begin : stimulus
		chr_beat_t beat;
		int        pick;
		int        idx;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, both alphabets, skipped characters, end marks.
		for (int r = 0; r < ROW_COUNT; r++) begin
			send_beat(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].result);
		end

		// Random phases, each with its own idle pattern. Mostly valid base64
		// text, with some padding and whitespace and a little raw noise.
		for (int phase = 0; phase < 4; phase++) begin
			tx_idle_pct = TX_IDLE_PCT[phase];
			rx_stall_pct = RX_STALL_PCT[phase];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					idx = $urandom_range(63);
					if (idx < 26) begin
						beat.char_in = CHAR_UPPER_A + 8'(idx);
					end else if (idx < 52) begin
						beat.char_in = CHAR_LOWER_A + 8'(idx - 26);
					end else if (idx < 62) begin
						beat.char_in = CHAR_DIGIT_0 + 8'(idx - 52);
					end else if (idx == 62) begin
						beat.char_in = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
					end else begin
						beat.char_in = $urandom_range(1) ? CHAR_SLASH : CHAR_UNDER;
					end
				end else if (pick < 90) begin
					case ($urandom_range(3))
						0: beat.char_in = "=";
						1: beat.char_in = 8'h0A;
						2: beat.char_in = 8'h0D;
						default: beat.char_in = " ";
					endcase
				end else begin
					beat.char_in = 8'($urandom_range(255));
				end
				beat.end_of_message = ($urandom_range(15) == 0);
				send_beat(beat, 1'b0, '0);
			end

			// Hold the sender off until every owed result has come back.
			chr_valid <= 1'b0;
			do @(posedge clk); while (owed_results.size() != 0);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d result beats never arrived", owed_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("PASS base64_stream_decoder");
		end else begin
			$display("FAIL base64_stream_decoder");
		end
		$finish;
	end

endmodule
